/* rtl/bra_pkg.sv */
package bra_pkg;

  // map geometry
  localparam int MAP_BITS  = 8192;
  localparam int MAP_AW    = $clog2(MAP_BITS);
  localparam int WORD_W    = 8;
  localparam int WORD_SEL  = $clog2(WORD_W);
  localparam int WORD_AW   = MAP_AW - WORD_SEL;
  localparam int MAP_WORDS = MAP_BITS / WORD_W;

  // field widths
  localparam int CNT_W = 14;

  localparam logic [CNT_W-1:0] TOTAL_RESET = CNT_W'(MAP_BITS);

  // command codes
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  // status codes
  localparam logic STAT_DONE     = 1'b0;
  localparam logic STAT_NO_SPACE = 1'b1;

  typedef struct packed {
    logic              command;
    logic [CNT_W-1:0]  num_clusters;
    logic [MAP_AW-1:0] first_cluster;
  } cmd_item_t;

  typedef struct packed {
    logic              status;
    logic [MAP_AW-1:0] grant_start;
    logic [CNT_W-1:0]  run_length;
  } result_t;

  // running free-run tracker shared by both scan passes
  typedef struct packed {
    logic [CNT_W-1:0]  cur_len;
    logic [MAP_AW-1:0] cur_start;
    logic [CNT_W-1:0]  best_len;
    logic [MAP_AW-1:0] best_first;
  } run_state_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN_FIT,
    S_SCAN_BEST,
    S_BEST_END,
    S_MARK,
    S_FINISH
  } state_t;

endpackage

/* rtl/bra_ram.sv */
module bra_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/bra_run_unit.sv */
module bra_run_unit (
  input  logic [bra_pkg::WORD_W-1:0]  word_in,
  input  logic [bra_pkg::WORD_AW-1:0] base,
  input  logic [bra_pkg::CNT_W-1:0]   lim,
  input  logic [bra_pkg::CNT_W-1:0]   want,
  input  logic                        fit_mode,
  input  bra_pkg::run_state_t         st_in,
  output bra_pkg::run_state_t         st_out,
  output logic                        hit
);

  // walk the bits of one map word in order, extending or closing free runs
  always_comb begin
    bra_pkg::run_state_t      st;
    logic                     h;
    logic [bra_pkg::MAP_AW-1:0] idx;
    logic                     used;
    st = st_in;
    h  = 1'b0;
    for (int b = 0; b < bra_pkg::WORD_W; b++) begin
      idx  = {base, bra_pkg::WORD_SEL'(b)};
      // clusters at or past the scan limit count as used
      used = word_in[b] | ({1'b0, idx} >= lim);
      if (!h) begin
        if (!used) begin
          if (st.cur_len == '0) begin
            st.cur_start = idx;
          end
          st.cur_len = st.cur_len + 1'b1;
          if (fit_mode && (st.cur_len == want)) begin
            h = 1'b1;
          end
        end else begin
          if (!fit_mode && (st.cur_len > st.best_len)) begin
            st.best_len   = st.cur_len;
            st.best_first = st.cur_start;
          end
          st.cur_len = '0;
        end
      end
    end
    st_out = st;
    hit    = h;
  end

endmodule

/* rtl/bitmap_run_allocator_top.sv */
// Contiguous run allocator over a one-bit-per-cluster map (1 = used).
// Command channel: in_valid / in_stall / in_item. An allocate grants the
// first free run of exactly the requested length below the cluster total,
// or failing that the longest free run (earliest on ties) as a partial
// grant, or reports no space. A free clears a range of map bits.
// Result channel: out_valid / out_stall / out_item, one item per command.
// Config: cfg_write loads cfg_data into the cluster total; write only when idle.
// Timing: the map sits in a RAM of 1024 words of 8 bits and one shared run
// tracker walks one word per cycle. An allocate scans for an exact fit,
// then, if none is found, scans again for the longest run; a granted run is
// then marked by a read-modify-write sweep over the words it touches before
// the result is handed over. A first-fit hit stops early. A free only marks
// its range. One command is worked at a
// time; a new one is taken once the previous result sits in the output
// register, even while the receiver stalls it.
// Reset: the map is cleared by a sweep over all 1024 words, one word per
// cycle, with in_stall high; the cluster total returns to 8192.
// A stalled result holds its value until taken.
module bitmap_run_allocator_top (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  bra_pkg::cmd_item_t        in_item,
  output logic                      out_valid,
  input  logic                      out_stall,
  output bra_pkg::result_t          out_item,
  input  logic                      cfg_write,
  input  logic [bra_pkg::CNT_W-1:0] cfg_data
);

  bra_pkg::state_t state, state_next;

  logic [bra_pkg::WORD_AW:0]   rd_addr, rd_addr_next;
  logic                        pend, pend_next;
  logic [bra_pkg::WORD_AW-1:0] proc_addr, proc_addr_next;

  bra_pkg::run_state_t run, run_next, unit_st;
  logic                unit_hit;
  logic                fit_mode;

  logic [bra_pkg::CNT_W-1:0] want, want_next;
  logic [bra_pkg::CNT_W-1:0] total, lim;
  logic [bra_pkg::CNT_W:0]   lim_round;
  logic [bra_pkg::WORD_AW:0] nbytes;

  logic                        mark_val, mark_val_next;
  logic [bra_pkg::MAP_AW-1:0]  mark_lo, mark_lo_next;
  logic [bra_pkg::CNT_W:0]     mark_end, mark_end_next;
  logic [bra_pkg::CNT_W:0]     last_bit;
  logic [bra_pkg::WORD_AW-1:0] mark_last;
  logic [bra_pkg::WORD_W-1:0]  mark_wdata;

  logic                       mk_go;
  logic [bra_pkg::MAP_AW-1:0] mk_start;
  logic [bra_pkg::CNT_W-1:0]  mk_len;
  logic [bra_pkg::CNT_W:0]    mk_sum;

  logic [bra_pkg::CNT_W-1:0]  fin_len;
  logic [bra_pkg::MAP_AW-1:0] fin_start;

  bra_pkg::result_t res, res_next, out_item_next;
  logic             out_valid_next;

  logic                        ram_we;
  logic [bra_pkg::WORD_AW-1:0] ram_waddr, ram_raddr;
  logic [bra_pkg::WORD_W-1:0]  ram_wdata, ram_rdata;

  // cluster map storage
  bra_ram #(
    .WIDTH (bra_pkg::WORD_W),
    .DEPTH (bra_pkg::MAP_WORDS)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // shared run tracker, one map word per cycle
  assign fit_mode = (state == bra_pkg::S_SCAN_FIT);

  bra_run_unit u_run (
    .word_in  (ram_rdata),
    .base     (proc_addr),
    .lim      (lim),
    .want     (want),
    .fit_mode (fit_mode),
    .st_in    (run),
    .st_out   (unit_st),
    .hit      (unit_hit)
  );

  // scan limit and number of words it covers
  assign lim = (total < bra_pkg::CNT_W'(bra_pkg::MAP_BITS)) ?
               total : bra_pkg::CNT_W'(bra_pkg::MAP_BITS);
  assign lim_round = {1'b0, lim} + (bra_pkg::CNT_W + 1)'(bra_pkg::WORD_W - 1);
  assign nbytes    = lim_round[bra_pkg::WORD_SEL +: (bra_pkg::WORD_AW + 1)];

  // last word touched by the marking sweep
  assign last_bit  = mark_end - 1'b1;
  assign mark_last = last_bit[bra_pkg::WORD_SEL +: bra_pkg::WORD_AW];

  // longest run once the last free stretch is closed
  assign fin_len   = (run.cur_len > run.best_len) ? run.cur_len : run.best_len;
  assign fin_start = (run.cur_len > run.best_len) ? run.cur_start : run.best_first;

  // read-modify-write data for the word being marked
  always_comb begin
    logic [bra_pkg::CNT_W:0] idx;
    mark_wdata = ram_rdata;
    for (int b = 0; b < bra_pkg::WORD_W; b++) begin
      idx = (bra_pkg::CNT_W + 1)'({proc_addr, bra_pkg::WORD_SEL'(b)});
      if ((idx >= (bra_pkg::CNT_W + 1)'(mark_lo)) && (idx < mark_end)) begin
        mark_wdata[b] = mark_val;
      end
    end
  end

  assign mk_sum = (bra_pkg::CNT_W + 1)'(mk_start) + (bra_pkg::CNT_W + 1)'(mk_len);

  // sequencer: next state, memory port control and result staging
  always_comb begin
    state_next     = state;
    rd_addr_next   = rd_addr;
    pend_next      = pend;
    proc_addr_next = proc_addr;
    run_next       = run;
    want_next      = want;
    mark_val_next  = mark_val;
    mark_lo_next   = mark_lo;
    mark_end_next  = mark_end;
    res_next       = res;
    out_item_next  = out_item;
    out_valid_next = out_valid;
    in_stall       = 1'b1;
    ram_we         = 1'b0;
    ram_waddr      = proc_addr;
    ram_wdata      = mark_wdata;
    ram_raddr      = rd_addr[bra_pkg::WORD_AW-1:0];
    mk_go          = 1'b0;
    mk_start       = '0;
    mk_len         = '0;

    // result taken by the receiver
    if (out_valid && !out_stall) begin
      out_valid_next = 1'b0;
    end

    case (state)
      bra_pkg::S_CLEAR: begin
        ram_we       = 1'b1;
        ram_waddr    = rd_addr[bra_pkg::WORD_AW-1:0];
        ram_wdata    = '0;
        rd_addr_next = rd_addr + 1'b1;
        if (rd_addr == (bra_pkg::WORD_AW + 1)'(bra_pkg::MAP_WORDS - 1)) begin
          rd_addr_next = '0;
          state_next   = bra_pkg::S_IDLE;
        end
      end

      bra_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          want_next = in_item.num_clusters;
          res_next  = '{status: bra_pkg::STAT_DONE, grant_start: '0, run_length: '0};
          if (in_item.command == bra_pkg::CMD_FREE) begin
            mark_val_next = 1'b0;
            mk_go         = 1'b1;
            mk_start      = in_item.first_cluster;
            mk_len        = in_item.num_clusters;
          end else begin
            run_next     = '0;
            rd_addr_next = '0;
            pend_next    = 1'b0;
            state_next   = bra_pkg::S_SCAN_FIT;
          end
        end
      end

      bra_pkg::S_SCAN_FIT, bra_pkg::S_SCAN_BEST: begin
        if (pend) begin
          run_next = unit_st;
        end
        // stream the next word
        if (rd_addr < nbytes) begin
          rd_addr_next   = rd_addr + 1'b1;
          pend_next      = 1'b1;
          proc_addr_next = rd_addr[bra_pkg::WORD_AW-1:0];
        end else begin
          pend_next = 1'b0;
        end
        if (fit_mode && pend && unit_hit) begin
          // exact-length run found
          mark_val_next = 1'b1;
          mk_go         = 1'b1;
          mk_start      = unit_st.cur_start;
          mk_len        = want;
          res_next      = '{status: bra_pkg::STAT_DONE, grant_start: unit_st.cur_start,
                            run_length: want};
        end else if (!pend && (rd_addr >= nbytes)) begin
          pend_next    = 1'b0;
          rd_addr_next = '0;
          if (fit_mode) begin
            run_next   = '0;
            state_next = bra_pkg::S_SCAN_BEST;
          end else begin
            state_next = bra_pkg::S_BEST_END;
          end
        end
      end

      bra_pkg::S_BEST_END: begin
        if (fin_len == '0) begin
          res_next   = '{status: bra_pkg::STAT_NO_SPACE, grant_start: '0, run_length: '0};
          state_next = bra_pkg::S_FINISH;
        end else begin
          mark_val_next = 1'b1;
          mk_go         = 1'b1;
          mk_start      = fin_start;
          mk_len        = fin_len;
          res_next      = '{status: bra_pkg::STAT_DONE, grant_start: fin_start,
                            run_length: fin_len};
        end
      end

      bra_pkg::S_MARK: begin
        // write back the word read in the previous cycle
        if (pend) begin
          ram_we    = 1'b1;
          ram_waddr = proc_addr;
          ram_wdata = mark_wdata;
        end
        if (rd_addr <= {1'b0, mark_last}) begin
          rd_addr_next   = rd_addr + 1'b1;
          pend_next      = 1'b1;
          proc_addr_next = rd_addr[bra_pkg::WORD_AW-1:0];
        end else begin
          pend_next = 1'b0;
          if (!pend) begin
            state_next = bra_pkg::S_FINISH;
          end
        end
      end

      bra_pkg::S_FINISH: begin
        if (!out_valid || !out_stall) begin
          out_valid_next = 1'b1;
          out_item_next  = res;
          state_next     = bra_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = bra_pkg::S_IDLE;
      end
    endcase

    // start a marking sweep over a clipped range
    if (mk_go) begin
      mark_lo_next  = mk_start;
      mark_end_next = (mk_sum > (bra_pkg::CNT_W + 1)'(bra_pkg::MAP_BITS)) ?
                      (bra_pkg::CNT_W + 1)'(bra_pkg::MAP_BITS) : mk_sum;
      rd_addr_next  = {1'b0, mk_start[bra_pkg::MAP_AW-1:bra_pkg::WORD_SEL]};
      pend_next     = 1'b0;
      state_next    = (mk_len == '0) ? bra_pkg::S_FINISH : bra_pkg::S_MARK;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= bra_pkg::S_CLEAR;
      rd_addr   <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
      total     <= bra_pkg::TOTAL_RESET;
    end else begin
      state     <= state_next;
      rd_addr   <= rd_addr_next;
      pend      <= pend_next;
      out_valid <= out_valid_next;
      if (cfg_write) begin
        total <= cfg_data;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    proc_addr <= proc_addr_next;
    run       <= run_next;
    want      <= want_next;
    mark_val  <= mark_val_next;
    mark_lo   <= mark_lo_next;
    mark_end  <= mark_end_next;
    res       <= res_next;
    out_item  <= out_item_next;
  end

endmodule

/* rtl/bra_checker.sv */
module bra_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      in_valid,
  input logic                      in_stall,
  input bra_pkg::cmd_item_t        in_item,
  input logic                      out_valid,
  input logic                      out_stall,
  input bra_pkg::result_t          out_item,
  input logic                      cfg_write,
  input logic [bra_pkg::CNT_W-1:0] cfg_data
);

  // a stalled result item holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("result item changed while stalled");

  // no-space result carries no run
  a_no_space_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_item.status == bra_pkg::STAT_NO_SPACE) |->
      (out_item.grant_start == '0) && (out_item.run_length == '0))
    else $error("no-space result with a run");

  // an empty grant starts at zero
  a_empty_start: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_item.run_length == '0) |-> (out_item.grant_start == '0))
    else $error("empty grant with non-zero start");

  // a granted run lies inside the map
  a_run_in_map: assert property (@(posedge clk) disable iff (rst)
    out_valid |->
      ((bra_pkg::CNT_W + 1)'(out_item.grant_start) +
       (bra_pkg::CNT_W + 1)'(out_item.run_length)) <=
      (bra_pkg::CNT_W + 1)'(bra_pkg::MAP_BITS))
    else $error("granted run runs past the map");

  // map clearing holds off commands straight after reset
  a_clear_stall: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> in_stall)
    else $error("command taken during map clearing");

endmodule

bind bitmap_run_allocator_top bra_checker u_bra_checker (.*);
